>>> hw/rtl/rarect_pkg.sv
// Shared constants and types for the ray against axis-aligned rectangle test.
package rarect_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // Plane orientation codes held in the axis register.
   localparam logic [1:0] AXIS_XY = 2'd0;
   localparam logic [1:0] AXIS_XZ = 2'd1;
   localparam logic [1:0] AXIS_YZ = 2'd2;
   // The remaining code selects no plane, so every ray misses.
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // Register indexes on the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_HIGH  = 3'd5;

   // Fields that ride alongside the t division.
   typedef struct packed {
      logic signed [31:0] org1;
      logic signed [31:0] org2;
      logic signed [31:0] dir1;
      logic signed [31:0] dir2;
      logic signed [31:0] tlo;
      logic signed [31:0] thi;
      logic               neg;
      logic               front;
      logic               miss;
   } pre_side_type;

   // Fields that ride alongside the u division.
   typedef struct packed {
      logic signed [31:0] t;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      logic               front;
   } post_side_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_t;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               front_face;
   } res_type;

endpackage

>>> hw/rtl/rarect_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rarect_div #(
   parameter int QW = 32,
   parameter int NW = 49,
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   // The dividend must be below den << QW; callers flag items that break this as misses.
   localparam int CW = (NW > DW + QW - 1) ? NW : DW + QW - 1;

   logic          vld_ff  [QW];
   logic [CW-1:0] rem_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_step
      logic          vld_src;
      logic [CW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic [CW-1:0] dsh;
      logic [CW:0]   diff;
      logic [CW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = CW'(in_num);
         assign quo_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      assign dsh  = CW'(den_src) << (QW - 1 - s);
      assign diff = {1'b0, rem_src} - {1'b0, dsh};

      always_comb begin
         quo_in = quo_src;
         quo_in[QW-1-s] = ~diff[CW];
         rem_in = diff[CW] ? rem_src : diff[CW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> hw/rtl/ray_axis_aligned_rect_intersect.sv
// Top level: pipelined ray against axis-aligned rectangle intersection test.
//
// Input items arrive on req_* (valid/stall); each yields exactly one result
// item on rsp_* (valid/stall), in order. A miss returns all fields zero.
// The rectangle is set through the csr_* write port (csr_ready is always
// high); registers must be written only while no item is in flight, which
// the block itself does not enforce. The pipeline runs through four setup
// stages, a 32-stage divider for t, four stages for signed t, products,
// bounds and differences, FRAC_BITS + 1 stages of the u and v dividers,
// then the output register. One item can enter every cycle while req_stall
// is low; the one-bit-per-stage dividers set the depth.
// A stalled result holds in the output register while one more item lands
// in a skid register; only then does req_stall rise and the whole pipeline
// hold. Reset clears all valid bits and loads the register reset values
// (XY plane at zero, unit square bounds at Q16.16).
module ray_axis_aligned_rect_intersect #(
   parameter int FRAC_BITS = rarect_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [31:0]                 req_origin_x,
   input  logic signed [31:0]                 req_origin_y,
   input  logic signed [31:0]                 req_origin_z,
   input  logic signed [31:0]                 req_dir_x,
   input  logic signed [31:0]                 req_dir_y,
   input  logic signed [31:0]                 req_dir_z,
   input  logic signed [31:0]                 req_t_lower,
   input  logic signed [31:0]                 req_t_upper,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [31:0]                 rsp_hit_t,
   output logic [FRAC_BITS:0]                 rsp_coord_u,
   output logic [FRAC_BITS:0]                 rsp_coord_v,
   output logic signed [31:0]                 rsp_point_x,
   output logic signed [31:0]                 rsp_point_y,
   output logic signed [31:0]                 rsp_point_z,
   output logic                               rsp_front_face,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rarect_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata
);

   localparam int NW = 33 + FRAC_BITS;   // |plane - origin| scaled
   localparam int AW = 65 - FRAC_BITS;   // in-plane coordinate before bounds
   localparam int UW = 32 + FRAC_BITS;   // scaled offset within the extent
   localparam int CU = FRAC_BITS + 1;    // coordinate width
   localparam int PSW = $bits(rarect_pkg::pre_side_type);
   localparam int QSW = $bits(rarect_pkg::post_side_type);

   // Configuration registers.
   logic [1:0]         axis_ff;
   logic signed [31:0] plane_offset_ff;
   logic signed [31:0] first_low_ff;
   logic signed [31:0] first_high_ff;
   logic signed [31:0] second_low_ff;
   logic signed [31:0] second_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff         <= rarect_pkg::AXIS_XY;
         plane_offset_ff <= '0;
         first_low_ff    <= '0;
         first_high_ff   <= 32'sd65536;
         second_low_ff   <= '0;
         second_high_ff  <= 32'sd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rarect_pkg::REG_AXIS:         axis_ff         <= csr_wdata[1:0];
            rarect_pkg::REG_PLANE_OFFSET: plane_offset_ff <= csr_wdata;
            rarect_pkg::REG_FIRST_LOW:    first_low_ff    <= csr_wdata;
            rarect_pkg::REG_FIRST_HIGH:   first_high_ff   <= csr_wdata;
            rarect_pkg::REG_SECOND_LOW:   second_low_ff   <= csr_wdata;
            rarect_pkg::REG_SECOND_HIGH:  second_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole pipeline moves together unless the skid register is occupied.
   logic adv;
   logic skid_valid_ff;
   assign adv       = ~skid_valid_ff;
   assign req_stall = ~adv;

   // Stage 0: input register.
   logic               v0_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff, tlo_ff, thi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff  <= req_origin_x;
         oy_ff  <= req_origin_y;
         oz_ff  <= req_origin_z;
         dx_ff  <= req_dir_x;
         dy_ff  <= req_dir_y;
         dz_ff  <= req_dir_z;
         tlo_ff <= req_t_lower;
         thi_ff <= req_t_upper;
      end
   end

   // Stage 1: pick the normal and in-plane axes, distance to the plane.
   logic signed [31:0]       org_n, den_n;
   logic signed [32:0]       diff_in;
   rarect_pkg::pre_side_type s1_in;
   logic                     v1_ff;
   logic signed [32:0]       diff1_ff;
   logic signed [31:0]       den1_ff;
   rarect_pkg::pre_side_type s1_ff;

   always_comb begin
      s1_in      = '0;
      s1_in.tlo  = tlo_ff;
      s1_in.thi  = thi_ff;
      org_n      = oz_ff;
      den_n      = dz_ff;
      s1_in.org1 = ox_ff;
      s1_in.org2 = oy_ff;
      s1_in.dir1 = dx_ff;
      s1_in.dir2 = dy_ff;
      case (axis_ff)
         rarect_pkg::AXIS_XY: ;
         rarect_pkg::AXIS_XZ: begin
            org_n      = oy_ff;
            den_n      = dy_ff;
            s1_in.org2 = oz_ff;
            s1_in.dir2 = dz_ff;
         end
         rarect_pkg::AXIS_YZ: begin
            org_n      = ox_ff;
            den_n      = dx_ff;
            s1_in.org1 = oy_ff;
            s1_in.dir1 = dy_ff;
            s1_in.org2 = oz_ff;
            s1_in.dir2 = dz_ff;
         end
         default: s1_in.miss = 1'b1;
      endcase
      s1_in.front = den_n[31];
      if (den_n == 32'sd0) begin
         s1_in.miss = 1'b1;
      end
      diff_in = 33'(plane_offset_ff) - 33'(org_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff1_ff <= diff_in;
         den1_ff  <= den_n;
         s1_ff    <= s1_in;
      end
   end

   // Stage 2: magnitudes and quotient sign.
   logic [32:0]              nabs_in;
   logic [31:0]              dabs_in;
   rarect_pkg::pre_side_type s2_in;
   logic                     v2_ff;
   logic [NW-1:0]            nmag2_ff;
   logic [31:0]              dmag2_ff;
   rarect_pkg::pre_side_type s2_ff;

   always_comb begin
      nabs_in    = diff1_ff[32] ? 33'(-diff1_ff) : 33'(diff1_ff);
      dabs_in    = den1_ff[31] ? 32'(-den1_ff) : 32'(den1_ff);
      s2_in      = s1_ff;
      s2_in.neg  = diff1_ff[32] ^ den1_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nmag2_ff <= NW'(nabs_in) << FRAC_BITS;
         dmag2_ff <= dabs_in;
         s2_ff    <= s2_in;
      end
   end

   // Stage 3: a quotient of 2^32 or more can never fit, flag it as a miss here.
   rarect_pkg::pre_side_type s3_in;
   logic                     v3_ff;
   logic [NW-1:0]            nmag3_ff;
   logic [31:0]              dmag3_ff;
   rarect_pkg::pre_side_type s3_ff;

   always_comb begin
      s3_in = s2_ff;
      if (64'(nmag2_ff) >= {dmag2_ff, 32'd0}) begin
         s3_in.miss = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nmag3_ff <= nmag2_ff;
         dmag3_ff <= dmag2_ff;
         s3_ff    <= s3_in;
      end
   end

   // Division for |t|.
   logic                     tdiv_valid;
   logic [31:0]              tdiv_quo;
   logic [PSW-1:0]           tdiv_side;
   rarect_pkg::pre_side_type sd;

   rarect_div #(
      .QW(32),
      .NW(NW),
      .DW(32),
      .SW(PSW)
   ) u_tdiv (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v3_ff),
      .in_num   (nmag3_ff),
      .in_den   (dmag3_ff),
      .in_side  (s3_ff),
      .out_valid(tdiv_valid),
      .out_quo  (tdiv_quo),
      .out_side (tdiv_side)
   );

   assign sd = rarect_pkg::pre_side_type'(tdiv_side);

   // Stage 4: signed t, range and window checks.
   logic signed [31:0]       t_in;
   logic                     miss4_in;
   logic                     v4_ff;
   logic signed [31:0]       t4_ff;
   logic                     miss4_ff;
   rarect_pkg::pre_side_type s4_ff;

   always_comb begin
      t_in     = sd.neg ? $signed(~tdiv_quo + 32'd1) : $signed(tdiv_quo);
      miss4_in = sd.miss;
      if (sd.neg ? (tdiv_quo > 32'h8000_0000) : tdiv_quo[31]) begin
         miss4_in = 1'b1;
      end
      if (t_in < sd.tlo || t_in > sd.thi) begin
         miss4_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= tdiv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t4_ff    <= t_in;
         miss4_ff <= miss4_in;
         s4_ff    <= sd;
      end
   end

   // Stage 5: t times the two in-plane direction components.
   logic                     v5_ff;
   logic signed [63:0]       p1_5_ff, p2_5_ff;
   logic signed [31:0]       t5_ff;
   logic                     miss5_ff;
   rarect_pkg::pre_side_type s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_5_ff  <= t4_ff * s4_ff.dir1;
         p2_5_ff  <= t4_ff * s4_ff.dir2;
         t5_ff    <= t4_ff;
         miss5_ff <= miss4_ff;
         s5_ff    <= s4_ff;
      end
   end

   // Stage 6: in-plane coordinates; the arithmetic shift floors the product.
   logic signed [63:0]   sh1, sh2;
   logic                 v6_ff;
   logic signed [AW-1:0] a1_6_ff, a2_6_ff;
   logic signed [31:0]   t6_ff;
   logic                 miss6_ff;
   logic                 front6_ff;

   assign sh1 = p1_5_ff >>> FRAC_BITS;
   assign sh2 = p2_5_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_6_ff   <= $signed(AW'(sh1)) + $signed(AW'(s5_ff.org1));
         a2_6_ff   <= $signed(AW'(sh2)) + $signed(AW'(s5_ff.org2));
         t6_ff     <= t5_ff;
         miss6_ff  <= miss5_ff;
         front6_ff <= s5_ff.front;
      end
   end

   // Stage 7: bounds, extents and offsets into the rectangle.
   logic signed [AW-1:0]      lo1e, hi1e, lo2e, hi2e;
   logic signed [32:0]        ext1, ext2;
   logic [31:0]               off1, off2;
   logic                      miss7_in;
   rarect_pkg::post_side_type s7_in;
   logic                      v7_ff;
   logic [UW-1:0]             num1_7_ff, num2_7_ff;
   logic [31:0]               ext1_7_ff, ext2_7_ff;
   logic                      miss7_ff;
   rarect_pkg::post_side_type s7_ff;

   always_comb begin
      lo1e = AW'(first_low_ff);
      hi1e = AW'(first_high_ff);
      lo2e = AW'(second_low_ff);
      hi2e = AW'(second_high_ff);
      ext1 = 33'(first_high_ff) - 33'(first_low_ff);
      ext2 = 33'(second_high_ff) - 33'(second_low_ff);
      off1 = 32'(a1_6_ff) - 32'(first_low_ff);
      off2 = 32'(a2_6_ff) - 32'(second_low_ff);
      miss7_in = miss6_ff;
      if (ext1 <= 33'sd0 || ext2 <= 33'sd0) begin
         miss7_in = 1'b1;
      end
      if (a1_6_ff < lo1e || a1_6_ff > hi1e || a2_6_ff < lo2e || a2_6_ff > hi2e) begin
         miss7_in = 1'b1;
      end
      s7_in.t     = t6_ff;
      s7_in.a1    = 32'(a1_6_ff);
      s7_in.a2    = 32'(a2_6_ff);
      s7_in.front = front6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_7_ff <= UW'(off1) << FRAC_BITS;
         num2_7_ff <= UW'(off2) << FRAC_BITS;
         ext1_7_ff <= 32'(ext1);
         ext2_7_ff <= 32'(ext2);
         miss7_ff  <= miss7_in;
         s7_ff     <= s7_in;
      end
   end

   // Divisions for u and v; the v divider carries the miss flag.
   logic                      udiv_valid, vdiv_valid;
   logic [CU-1:0]             u_quo, v_quo;
   logic [QSW-1:0]            udiv_side;
   logic                      vdiv_miss;
   rarect_pkg::post_side_type fin;

   rarect_div #(
      .QW(CU),
      .NW(UW),
      .DW(32),
      .SW(QSW)
   ) u_udiv (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v7_ff),
      .in_num   (num1_7_ff),
      .in_den   (ext1_7_ff),
      .in_side  (s7_ff),
      .out_valid(udiv_valid),
      .out_quo  (u_quo),
      .out_side (udiv_side)
   );

   rarect_div #(
      .QW(CU),
      .NW(UW),
      .DW(32),
      .SW(1)
   ) u_vdiv (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v7_ff),
      .in_num   (num2_7_ff),
      .in_den   (ext2_7_ff),
      .in_side  (miss7_ff),
      .out_valid(vdiv_valid),
      .out_quo  (v_quo),
      .out_side (vdiv_miss)
   );

   assign fin = rarect_pkg::post_side_type'(udiv_side);

   // Result assembly; a miss returns all zeros.
   logic                pipe_valid;
   rarect_pkg::res_type res_in;
   logic [CU-1:0]       cu_in, cv_in;

   assign pipe_valid = udiv_valid & vdiv_valid;

   always_comb begin
      res_in = '0;
      cu_in  = '0;
      cv_in  = '0;
      if (!vdiv_miss) begin
         res_in.hit        = 1'b1;
         res_in.hit_t      = fin.t;
         res_in.front_face = fin.front;
         cu_in             = u_quo;
         cv_in             = v_quo;
         case (axis_ff)
            rarect_pkg::AXIS_XZ: begin
               res_in.point_x = fin.a1;
               res_in.point_y = plane_offset_ff;
               res_in.point_z = fin.a2;
            end
            rarect_pkg::AXIS_YZ: begin
               res_in.point_x = plane_offset_ff;
               res_in.point_y = fin.a1;
               res_in.point_z = fin.a2;
            end
            default: begin
               res_in.point_x = fin.a1;
               res_in.point_y = fin.a2;
               res_in.point_z = plane_offset_ff;
            end
         endcase
      end
   end

   // Output register with one skid entry behind it.
   logic                out_valid_ff;
   rarect_pkg::res_type out_res_ff, skid_res_ff;
   logic [CU-1:0]       out_u_ff, out_v_ff, skid_u_ff, skid_v_ff;
   logic                out_free;

   assign out_free = ~out_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | pipe_valid;
         skid_valid_ff <= 1'b0;
      end else if (pipe_valid && adv) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_res_ff <= skid_res_ff;
            out_u_ff   <= skid_u_ff;
            out_v_ff   <= skid_v_ff;
         end else begin
            out_res_ff <= res_in;
            out_u_ff   <= cu_in;
            out_v_ff   <= cv_in;
         end
      end else if (adv) begin
         skid_res_ff <= res_in;
         skid_u_ff   <= cu_in;
         skid_v_ff   <= cv_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_res_ff.hit;
   assign rsp_hit_t      = out_res_ff.hit_t;
   assign rsp_coord_u    = out_u_ff;
   assign rsp_coord_v    = out_v_ff;
   assign rsp_point_x    = out_res_ff.point_x;
   assign rsp_point_y    = out_res_ff.point_y;
   assign rsp_point_z    = out_res_ff.point_z;
   assign rsp_front_face = out_res_ff.front_face;

endmodule
